FILE: design/message_framing_record_parser_macros.svh
// Assertion macros shared by the parser RTL.
`ifndef MESSAGE_FRAMING_RECORD_PARSER_MACROS_SVH
`define MESSAGE_FRAMING_RECORD_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MFRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser assertion failed (same cycle)");

// Next-cycle implication, checked out of reset.
`define MFRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser assertion failed (next cycle)");

`endif

FILE: design/mfrp_pkg.sv
`default_nettype none

package mfrp_pkg;

    typedef enum logic [12:0] {
        PH_TYPE      = 13'b0000000000001,
        PH_VER_MAJ   = 13'b0000000000010,
        PH_VER_MIN   = 13'b0000000000100,
        PH_MODE_TYPE = 13'b0000000001000,
        PH_MODE_VAL  = 13'b0000000010000,
        PH_VIA_TYPE  = 13'b0000000100000,
        PH_VIA_LEN   = 13'b0000001000000,
        PH_VIA_DATA  = 13'b0000010000000,
        PH_ENC_TYPE  = 13'b0000100000000,
        PH_ENC_VAL   = 13'b0001000000000,
        PH_ENC_END   = 13'b0010000000000,
        PH_ENV_LEN   = 13'b0100000000000,
        PH_ENV_DATA  = 13'b1000000000000
    } phase_t;

    typedef enum logic [1:0] {
        KIND_URL   = 2'd0,
        KIND_ENV   = 2'd1,
        KIND_REPLY = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // record types
    localparam logic [7:0] REC_PREAMBLE = 8'h00;
    localparam logic [7:0] REC_ENVELOPE = 8'h06;
    localparam logic [7:0] REC_END      = 8'h07;

    // fixed preamble bytes
    localparam logic [7:0] VER_MAJOR    = 8'h01;
    localparam logic [7:0] VER_MINOR    = 8'h00;
    localparam logic [7:0] MODE_TYPE    = 8'h01;
    localparam logic [7:0] MODE_DUPLEX  = 8'h02;
    localparam logic [7:0] VIA_TYPE     = 8'h02;
    localparam logic [7:0] ENC_TYPE     = 8'h03;
    localparam logic [7:0] ENC_VAL      = 8'h00;
    localparam logic [7:0] ENC_BINARY   = 8'h0C;

    // reply bytes
    localparam logic [7:0] REPLY_ACK    = 8'h0B;
    localparam logic [7:0] REPLY_END    = 8'h07;

    localparam int unsigned SHIFT_W = 3;

endpackage

`default_nettype wire

FILE: design/message_framing_record_parser.sv
// An accepted rx_byte is registered in the input stage (rx_reg) and its result in the
// output register, where the result is held while out_stall is high.
// Throughput: one byte per cycle; a byte that gives a result waits only while the
// output register is held by out_stall, a byte with no result never waits.
// Reset (rst_n, async, active low) empties both stages and returns the parser to
// the record-type phase with the connection open; no clearing pass is needed.
`default_nettype none

module message_framing_record_parser #(
    parameter int LEN_BITS = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [7:0]      data,
    output logic            last,
    output logic            conn_end
);

    `include "message_framing_record_parser_macros.svh"

    localparam int MAX_GROUPS = (LEN_BITS + 6) / 7;
    localparam int VW         = 7 * MAX_GROUPS + 1;
    localparam int SW         = mfrp_pkg::SHIFT_W;
    localparam logic [SW-1:0] SHIFT_LAST = SW'(MAX_GROUPS - 1);

    // input stage
    logic       s1_v_reg;
    logic [7:0] rx_reg;

    // parser state
    mfrp_pkg::phase_t      phase_reg, phase_next;
    logic [LEN_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic [LEN_BITS-1:0]   accum_reg, accum_next;
    logic [SW-1:0]         shift_reg, shift_next;
    logic                  closed_reg, closed_next;

    // result register
    logic                  out_v_reg;
    mfrp_pkg::kind_t       kind_reg;
    logic [7:0]            data_reg;
    logic                  last_reg;
    logic                  end_reg;

    // result of the byte in the input stage
    logic                  res_v;
    mfrp_pkg::kind_t       res_kind;
    logic [7:0]            res_data;
    logic                  res_last;
    logic                  res_end;

    logic                  out_free;
    logic                  s1_go;

    // varint group
    logic [5:0]            sh_amt;
    logic [VW-1:0]         grp_wide;
    logic                  grp_ovf;
    logic [LEN_BITS-1:0]   len_val;

    assign sh_amt   = {shift_reg, 3'b000} - {3'b000, shift_reg};
    assign grp_wide = {{(VW-7){1'b0}}, rx_reg[6:0]} << sh_amt;
    assign grp_ovf  = |grp_wide[VW-1:LEN_BITS];
    assign len_val  = accum_reg | grp_wide[LEN_BITS-1:0];

    always_comb
    begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        accum_next      = accum_reg;
        shift_next      = shift_reg;
        closed_next     = closed_reg;
        res_v           = 1'b0;
        res_kind        = mfrp_pkg::KIND_ERROR;
        res_data        = 8'h00;
        res_last        = 1'b0;
        res_end         = 1'b0;

        if (!closed_reg)
        begin
            unique case (phase_reg)
                mfrp_pkg::PH_TYPE:
                begin
                    if (rx_reg == mfrp_pkg::REC_PREAMBLE)
                    begin
                        phase_next = mfrp_pkg::PH_VER_MAJ;
                    end
                    else if (rx_reg == mfrp_pkg::REC_ENVELOPE)
                    begin
                        accum_next = '0;
                        shift_next = '0;
                        phase_next = mfrp_pkg::PH_ENV_LEN;
                    end
                    else if (rx_reg == mfrp_pkg::REC_END)
                    begin
                        closed_next = 1'b1;
                        res_v       = 1'b1;
                        res_kind    = mfrp_pkg::KIND_REPLY;
                        res_data    = mfrp_pkg::REPLY_END;
                        res_end     = 1'b1;
                    end
                    else
                    begin
                        res_v = 1'b1;
                    end
                end
                mfrp_pkg::PH_VER_MAJ:
                begin
                    if (rx_reg == mfrp_pkg::VER_MAJOR) phase_next = mfrp_pkg::PH_VER_MIN;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_VER_MIN:
                begin
                    if (rx_reg == mfrp_pkg::VER_MINOR) phase_next = mfrp_pkg::PH_MODE_TYPE;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_MODE_TYPE:
                begin
                    if (rx_reg == mfrp_pkg::MODE_TYPE) phase_next = mfrp_pkg::PH_MODE_VAL;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_MODE_VAL:
                begin
                    if (rx_reg == mfrp_pkg::MODE_DUPLEX) phase_next = mfrp_pkg::PH_VIA_TYPE;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_VIA_TYPE:
                begin
                    accum_next = '0;
                    shift_next = '0;
                    if (rx_reg == mfrp_pkg::VIA_TYPE) phase_next = mfrp_pkg::PH_VIA_LEN;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_VIA_LEN, mfrp_pkg::PH_ENV_LEN:
                begin
                    if (grp_ovf)
                    begin
                        res_v = 1'b1;
                    end
                    else if (rx_reg[7])
                    begin
                        // more groups follow
                        accum_next = len_val;
                        if (shift_reg == SHIFT_LAST) res_v = 1'b1;
                        else shift_next = shift_reg + 1'b1;
                    end
                    else if (len_val == '0)
                    begin
                        res_v = 1'b1;
                    end
                    else
                    begin
                        bytes_left_next = len_val;
                        accum_next      = '0;
                        shift_next      = '0;
                        phase_next      = (phase_reg == mfrp_pkg::PH_VIA_LEN) ?
                                          mfrp_pkg::PH_VIA_DATA : mfrp_pkg::PH_ENV_DATA;
                    end
                end
                mfrp_pkg::PH_VIA_DATA, mfrp_pkg::PH_ENV_DATA:
                begin
                    bytes_left_next = bytes_left_reg - 1'b1;
                    res_v           = 1'b1;
                    res_kind        = (phase_reg == mfrp_pkg::PH_VIA_DATA) ?
                                      mfrp_pkg::KIND_URL : mfrp_pkg::KIND_ENV;
                    res_data        = rx_reg;
                    res_last        = (bytes_left_reg == LEN_BITS'(1));
                    if (res_last)
                    begin
                        phase_next = (phase_reg == mfrp_pkg::PH_VIA_DATA) ?
                                     mfrp_pkg::PH_ENC_TYPE : mfrp_pkg::PH_TYPE;
                    end
                end
                mfrp_pkg::PH_ENC_TYPE:
                begin
                    if (rx_reg == mfrp_pkg::ENC_TYPE) phase_next = mfrp_pkg::PH_ENC_VAL;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_ENC_VAL:
                begin
                    if (rx_reg == mfrp_pkg::ENC_VAL) phase_next = mfrp_pkg::PH_ENC_END;
                    else res_v = 1'b1;
                end
                mfrp_pkg::PH_ENC_END:
                begin
                    if (rx_reg == mfrp_pkg::ENC_BINARY)
                    begin
                        phase_next = mfrp_pkg::PH_TYPE;
                        res_v      = 1'b1;
                        res_kind   = mfrp_pkg::KIND_REPLY;
                        res_data   = mfrp_pkg::REPLY_ACK;
                    end
                    else
                    begin
                        res_v = 1'b1;
                    end
                end
                default:
                begin
                    res_v = 1'b1;
                end
            endcase

            // any error result closes the connection
            if (res_v && (res_kind == mfrp_pkg::KIND_ERROR))
            begin
                closed_next = 1'b1;
                phase_next  = mfrp_pkg::PH_TYPE;
                res_end     = 1'b1;
                res_data    = 8'h00;
                res_last    = 1'b0;
            end
        end
    end

    // a byte with no result never waits on the output side
    assign out_free = !out_v_reg || !out_stall;
    assign s1_go    = s1_v_reg && (!res_v || out_free);
    assign in_stall = s1_v_reg && !s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg       <= 1'b0;
            phase_reg      <= mfrp_pkg::PH_TYPE;
            bytes_left_reg <= '0;
            accum_reg      <= '0;
            shift_reg      <= '0;
            closed_reg     <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall) s1_v_reg <= 1'b1;
            else if (s1_go)            s1_v_reg <= 1'b0;

            if (s1_go)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                accum_reg      <= accum_next;
                shift_reg      <= shift_next;
                closed_reg     <= closed_next;
            end

            if (s1_go && res_v) out_v_reg <= 1'b1;
            else if (!out_stall) out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) rx_reg <= rx_byte;
        // load the result register
        if (s1_go && res_v)
        begin
            kind_reg <= res_kind;
            data_reg <= res_data;
            last_reg <= res_last;
            end_reg  <= res_end;
        end
    end

    assign out_valid = out_v_reg;
    assign kind      = kind_reg;
    assign data      = data_reg;
    assign last      = last_reg;
    assign conn_end  = end_reg;

    `MFRP_ASSERT_NEXT(a_closed_sticky, closed_reg, closed_reg)
    `MFRP_ASSERT_NOW(a_error_closes,
        out_v_reg && (kind_reg == mfrp_pkg::KIND_ERROR), end_reg && (data_reg == 8'h00))
    `MFRP_ASSERT_NOW(a_last_on_payload,
        out_v_reg && last_reg,
        (kind_reg == mfrp_pkg::KIND_URL) || (kind_reg == mfrp_pkg::KIND_ENV))
    `MFRP_ASSERT_NOW(a_data_len_nonzero,
        (phase_reg == mfrp_pkg::PH_VIA_DATA) || (phase_reg == mfrp_pkg::PH_ENV_DATA),
        bytes_left_reg != '0)
    `MFRP_ASSERT_NOW(a_end_means_closed, out_v_reg && end_reg, closed_reg)
    `MFRP_ASSERT_NOW(a_closed_no_result, s1_go && closed_reg, !res_v)

endmodule

`default_nettype wire
